/* hw/rtl/parity_symbol_cell_mapper_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the parity symbol cell mapper.
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PARITY_SYMBOL_CELL_MAPPER_CORE_ASSERT_SVH
`define PARITY_SYMBOL_CELL_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, inactive while reset is held.
`define PSCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pscm: same-cycle check failed");

// Next-cycle implication, inactive while reset is held.
`define PSCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pscm: next-cycle check failed");

// Next-cycle implication that stays active through reset.
`define PSCM_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pscm: reset check failed");

`endif

/* hw/rtl/pscm_pkg.sv */
// ----------------------------------------------------------------------------
// pscm_pkg
// Types and constants shared by the parity symbol cell mapper modules.
// ----------------------------------------------------------------------------
package pscm_pkg;

    localparam int unsigned CORNER_CELLS = 10;
    localparam logic [7:0]  CORNER_SIZE  = 8'(CORNER_CELLS);
    localparam logic [8:0]  CORNER_FIT   = 9'(CORNER_CELLS + 1);
    localparam logic [8:0]  CORNER_SPAN  = 9'(2 * CORNER_CELLS + 1);

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam int unsigned HOLD_DEPTH = 4;

    localparam logic [12:0] PARITY_BITS_RESET = 13'd256;
    localparam logic [12:0] PARITY_BITS_MIN   = 13'd8;
    localparam logic [12:0] PARITY_BITS_MAX   = 13'd4096;
    localparam logic [7:0]  GRID_COLUMNS_RESET = 8'd180;
    localparam logic [7:0]  GRID_ROWS_RESET    = 8'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PARITY_BLOCK_BITS = 2'd0,
        CFG_GRID_COLUMNS      = 2'd1,
        CFG_GRID_ROWS         = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [12:0] parity_block_bits;
        logic [7:0]  grid_columns;
        logic [7:0]  grid_rows;
    } cfg_t;

    typedef struct packed {
        logic [2:0] symbol;
        logic       last;
    } sym_entry_t;

endpackage

/* hw/rtl/pscm_front.sv */
// ----------------------------------------------------------------------------
// pscm_front
// Splits each byte into bits, inserts the odd parity bit and packs 3-bit
// symbols into a hold buffer that drains one symbol per cycle unless q_full.
// ----------------------------------------------------------------------------
module pscm_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pscm_pkg::cfg_t                   cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pscm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             q_push,
    output pscm_pkg::sym_entry_t             q_push_data,
    input  logic                             q_full
);
    import pscm_pkg::*;

    logic [1:0]  pend_bits_reg, pend_bits_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [11:0] blk_cnt_reg, blk_cnt_next;
    logic        ones_reg, ones_next;
    logic [2:0]  hold_cnt_reg, hold_cnt_next;
    sym_entry_t  hold_reg [HOLD_DEPTH];
    sym_entry_t  hold_next [HOLD_DEPTH];

    logic        accept;
    logic [12:0] limit;
    logic [12:0] blk_inc;
    logic [12:0] gap;
    logic        reached;
    logic        insert;
    logic [2:0]  split;
    logic [7:0]  mask;
    logic        parity;
    logic [8:0]  data_ext;
    logic [8:0]  data_sh;
    logic [8:0]  new_bits;
    logic [11:0] new_ext;
    logic [11:0] stream;
    logic [3:0]  total_bits;
    logic [1:0]  full_syms;
    logic [1:0]  left_bits;
    logic [2:0]  tail;
    logic [2:0]  syms_out;

    assign q_push      = (hold_cnt_reg != 3'd0) && !q_full;
    assign q_push_data = hold_reg[0];
    assign s_tready    = (hold_cnt_reg == 3'd0) || ((hold_cnt_reg == 3'd1) && q_push);
    assign accept      = s_tvalid && s_tready;

    always_comb begin
        if (cfg.parity_block_bits < PARITY_BITS_MIN) begin
            limit = PARITY_BITS_MIN;
        end else if (cfg.parity_block_bits > PARITY_BITS_MAX) begin
            limit = PARITY_BITS_MAX;
        end else begin
            limit = cfg.parity_block_bits;
        end
        blk_inc = {1'b0, blk_cnt_reg} + 13'd1;
        reached = blk_inc >= limit;
        gap     = limit - blk_inc;
        insert  = reached || (gap <= 13'd7);
        split   = reached ? 3'd0 : gap[2:0];

        for (int i = 0; i < 8; i++) begin
            mask[i] = 3'(i) <= split;
        end
        parity = ~(ones_reg ^ (^(s_tdata & mask)));

        data_ext = {1'b0, s_tdata};
        data_sh  = {s_tdata, 1'b0};
        for (int k = 0; k < 9; k++) begin
            if (!insert || (4'(k) <= {1'b0, split})) begin
                new_bits[k] = data_ext[k];
            end else if (4'(k) == ({1'b0, split} + 4'd1)) begin
                new_bits[k] = parity;
            end else begin
                new_bits[k] = data_sh[k];
            end
        end
        new_ext = {3'b000, new_bits};

        case (pend_cnt_reg)
            2'd1:    stream = {new_ext[10:0], pend_bits_reg[0]};
            2'd2:    stream = {new_ext[9:0], pend_bits_reg[0], pend_bits_reg[1]};
            default: stream = new_ext;
        endcase

        total_bits = {2'b00, pend_cnt_reg} + (insert ? 4'd9 : 4'd8);
        case (total_bits)
            4'd9: begin
                full_syms = 2'd3;
                left_bits = 2'd0;
            end
            4'd10: begin
                full_syms = 2'd3;
                left_bits = 2'd1;
            end
            4'd11: begin
                full_syms = 2'd3;
                left_bits = 2'd2;
            end
            default: begin
                full_syms = 2'd2;
                left_bits = 2'd2;
            end
        endcase
        tail     = (full_syms == 2'd3) ? stream[11:9] : stream[8:6];
        syms_out = {1'b0, full_syms} + ((s_tlast && (left_bits != 2'd0)) ? 3'd1 : 3'd0);
    end

    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        blk_cnt_next   = blk_cnt_reg;
        ones_next      = ones_reg;
        hold_cnt_next  = hold_cnt_reg;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            hold_next[i] = hold_reg[i];
        end

        if (q_push) begin
            for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                hold_next[i] = hold_reg[i + 1];
            end
            hold_cnt_next = hold_cnt_reg - 3'd1;
        end

        if (accept) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                hold_next[i].symbol = {stream[3 * i], stream[3 * i + 1], stream[3 * i + 2]};
                hold_next[i].last   = s_tlast && ((3'(i) + 3'd1) == syms_out);
            end
            hold_cnt_next = syms_out;
            if (s_tlast) begin
                pend_bits_next = 2'd0;
                pend_cnt_next  = 2'd0;
                blk_cnt_next   = 12'd0;
                ones_next      = 1'b0;
            end else begin
                case (left_bits)
                    2'd1:    pend_bits_next = {1'b0, tail[0]};
                    2'd2:    pend_bits_next = {tail[0], tail[1]};
                    default: pend_bits_next = 2'd0;
                endcase
                pend_cnt_next = left_bits;
                if (insert) begin
                    blk_cnt_next = {9'd0, 3'd7 - split};
                    ones_next    = ^(s_tdata & ~mask);
                end else begin
                    blk_cnt_next = blk_cnt_reg + 12'd8;
                    ones_next    = ones_reg ^ (^s_tdata);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= 2'd0;
            pend_cnt_reg  <= 2'd0;
            blk_cnt_reg   <= 12'd0;
            ones_reg      <= 1'b0;
            hold_cnt_reg  <= 3'd0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            blk_cnt_reg   <= blk_cnt_next;
            ones_reg      <= ones_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            hold_reg[i] <= hold_next[i];
        end
    end

endmodule

/* hw/rtl/pscm_queue.sv */
// ----------------------------------------------------------------------------
// pscm_queue
// Short first-in first-out queue of symbols between front and back.
// ----------------------------------------------------------------------------
module pscm_queue #(
    parameter int unsigned DEPTH = pscm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  pscm_pkg::sym_entry_t push_data,
    output logic                 full,
    input  logic                 pop,
    output pscm_pkg::sym_entry_t head,
    output logic                 empty
);
    import pscm_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    sym_entry_t      mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = count_reg == FULL_COUNT;
    assign empty   = count_reg == '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/pscm_back.sv */
// ----------------------------------------------------------------------------
// pscm_back
// With a symbol queued, walks the column-major grid one column test per
// cycle, puts it in the next data cell and holds it in the output register.
// ----------------------------------------------------------------------------
module pscm_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pscm_pkg::cfg_t                   cfg,
    input  logic                             q_empty,
    input  pscm_pkg::sym_entry_t             q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pscm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import pscm_pkg::*;

    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [15:0] frame_reg, frame_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_col_reg, out_col_next;
    logic [7:0]  out_row_reg, out_row_next;
    logic [15:0] out_frame_reg, out_frame_next;
    logic [2:0]  out_sym_reg, out_sym_next;
    logic        out_last_reg, out_last_next;

    logic [8:0]  cols9;
    logic [8:0]  rows9;
    logic        has_data;
    logic        col_wrap;
    logic        interior;
    logic        col_corner;
    logic [7:0]  row_low;
    logic [7:0]  cand;
    logic        fits;
    logic        found;
    logic        out_free;
    logic        emit;
    logic [7:0]  emit_col;
    logic [7:0]  emit_row;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_sym_reg, out_frame_reg, out_row_reg, out_col_reg};

    always_comb begin
        cols9    = {1'b0, cfg.grid_columns};
        rows9    = {1'b0, cfg.grid_rows};
        has_data = ((cols9 >= CORNER_SPAN) && (rows9 >= 9'd3))
                || ((cols9 >= 9'd3) && (rows9 >= CORNER_SPAN));
        col_wrap   = col_reg >= cfg.grid_columns;
        interior   = (col_reg != 8'd0) && (({1'b0, col_reg} + 9'd1) < cols9);
        col_corner = (col_reg < CORNER_SIZE)
                  || (({1'b0, col_reg} + {1'b0, CORNER_SIZE}) >= cols9);
        row_low    = col_corner ? CORNER_SIZE : 8'd1;
        cand       = (row_reg > row_low) ? row_reg : row_low;
        fits       = col_corner ? (({1'b0, cand} + CORNER_FIT) <= rows9)
                                : (({1'b0, cand} + 9'd2) <= rows9);
        found      = !col_wrap && interior && fits;
        out_free   = !m_valid_reg || m_tready;
    end

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        frame_next     = frame_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_frame_next = out_frame_reg;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        emit           = 1'b0;
        emit_col       = 8'd0;
        emit_row       = 8'd0;

        if (!q_empty) begin
            if (!has_data) begin
                emit = out_free;
            end else if (col_wrap) begin
                col_next   = 8'd0;
                row_next   = 8'd0;
                frame_next = frame_reg + 16'd1;
            end else if (found) begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_col = col_reg;
                    emit_row = cand;
                    row_next = cand + 8'd1;
                end
            end else begin
                col_next = col_reg + 8'd1;
                row_next = 8'd0;
            end
        end

        q_pop = emit;
        if (emit) begin
            out_col_next   = emit_col;
            out_row_next   = emit_row;
            out_frame_next = frame_reg;
            out_sym_next   = q_head.symbol;
            out_last_next  = q_head.last;
            if (q_head.last) begin
                col_next   = 8'd1;
                row_next   = CORNER_SIZE;
                frame_next = 16'd0;
            end
        end
        m_valid_next = out_free ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= 8'd1;
            row_reg     <= CORNER_SIZE;
            frame_reg   <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            frame_reg   <= frame_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_frame_reg <= out_frame_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
    end

endmodule

/* hw/rtl/parity_symbol_cell_mapper_core.sv */
// ----------------------------------------------------------------------------
// parity_symbol_cell_mapper_core
// Odd parity insertion, 3-bit symbol packing and grid cell placement.
// ----------------------------------------------------------------------------
// The input stream carries one payload byte per transfer in s_tdata[7:0];
// s_tlast marks the last byte of a run and flushes a zero-padded partial
// symbol. Each output transfer carries one symbol with its cell column
// (m_tdata[7:0]), cell row (m_tdata[15:8]), frame index (m_tdata[31:16])
// and symbol (m_tdata[34:32]); m_tlast flags the final symbol of a run.
// The configuration channel writes parity block length, grid columns and
// grid rows by index and is always ready; write it only while idle.
// The first symbol of a byte passes through the front's hold buffer, the
// queue and the output register when the walk already stands on a data cell.
// A byte yields two to four symbols and the front releases one symbol per
// cycle while the queue is not full; it takes a new byte only when its hold
// buffer is empty or its last symbol is being pushed. The grid walk places
// one symbol per cycle while the output register is free and spends an extra
// step on every column it passes; fewer than 21 rows leave the corner
// columns without data cells. A four-entry queue absorbs the short gaps.
// Reset restores the register defaults and puts the walk at the first data
// cell of frame zero. When the receiver stalls, the output register holds
// its transfer, the queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module parity_symbol_cell_mapper_core #(
    parameter int unsigned QUEUE_DEPTH = pscm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pscm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pscm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: data_byte[7:0]
    input  logic [pscm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: cell_column[7:0], cell_row[15:8], frame_index[31:16],
    // cell_symbol[34:32], zero fill[39:35]
    output logic [pscm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import pscm_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       q_push;
    sym_entry_t q_push_data;
    logic       q_full;
    logic       q_pop;
    sym_entry_t q_head;
    logic       q_empty;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PARITY_BLOCK_BITS: cfg_next.parity_block_bits = cfg_data;
                CFG_GRID_COLUMNS:      cfg_next.grid_columns = cfg_data[7:0];
                CFG_GRID_ROWS:         cfg_next.grid_rows = cfg_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.parity_block_bits <= PARITY_BITS_RESET;
            cfg_reg.grid_columns      <= GRID_COLUMNS_RESET;
            cfg_reg.grid_rows         <= GRID_ROWS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pscm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full)
    );

    pscm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    pscm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/pscm_checker.sv */
// ----------------------------------------------------------------------------
// pscm_checker
// Port-level checks for the parity symbol cell mapper, bound to the top.
// ----------------------------------------------------------------------------
`include "parity_symbol_cell_mapper_core_assert.svh"

module pscm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pscm_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tlast
);

    logic cell_ok;

    assign cell_ok = (m_tdata[7:0] != 8'hff) && (m_tdata[15:8] != 8'hff)
                  && (m_tdata[39:35] == 5'd0);

    `PSCM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `PSCM_ASSERT_RST(a_reset_idle, aclk, !aresetn, !m_tvalid && s_tready)
    `PSCM_ASSERT_IMP(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)
    `PSCM_ASSERT_IMP(a_cell_range, aclk, aresetn, m_tvalid, cell_ok)

endmodule

bind parity_symbol_cell_mapper_core pscm_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);
